/* src/p4sw_pkg.sv */
// Shared types and constants for the packed 4bpp span writer.
package p4sw_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [2:0] CFG_CLIP_RIGHT  = 3'd1;
  localparam logic [2:0] CFG_CLIP_TOP    = 3'd2;
  localparam logic [2:0] CFG_CLIP_BOTTOM = 3'd3;
  localparam logic [2:0] CFG_ROW_STRIDE  = 3'd4;

  // Widths
  localparam int CoordW = 13;
  localparam int AddrW  = 23;
  localparam int StrideW = 12;
  localparam int CfgW   = 13;

  // Longest span after saturation
  localparam logic [12:0] MAX_WIDTH = 13'd4096;

  // Nibble masks
  localparam logic [7:0] HI_MASK = 8'hF0;
  localparam logic [7:0] LO_MASK = 8'h0F;

  typedef struct packed {
    logic [12:0] clip_left;
    logic [12:0] clip_right;
    logic [12:0] clip_top;
    logic [12:0] clip_bottom;
    logic [11:0] row_stride;
  } cfg_t;

  // One framebuffer byte write
  typedef struct packed {
    logic [22:0] addr;
    logic [7:0]  data;
    logic        wr_hi;
    logic        wr_lo;
    logic        last;
  } wr_t;

  // Writes produced by one accepted transaction, first in order in first
  typedef struct packed {
    logic [1:0] n;
    wr_t        first;
    wr_t        second;
  } push_t;

endpackage

/* src/p4sw_span.sv */
// Span state and per-transaction write generation with clipping and realignment.
module p4sw_span (
  input  logic                 clk,
  input  logic                 rst_n,
  input  p4sw_pkg::cfg_t       cfg,
  input  logic                 acc,
  input  logic                 span_start,
  input  logic signed [12:0]   start_x,
  input  logic signed [12:0]   row_y,
  input  logic [12:0]          span_width,
  input  logic [7:0]           pixel_pair,
  output p4sw_pkg::push_t      push
);
  import p4sw_pkg::*;

  logic signed [13:0] next_col_r, next_col_nxt;
  logic [12:0]        pix_left_r, pix_left_nxt;
  logic [22:0]        row_base_r, row_base_nxt;
  logic               row_vis_r, row_vis_nxt;
  logic [3:0]         held_r, held_nxt;
  logic               held_vld_r, held_vld_nxt;

  logic signed [13:0] cur_col;
  logic [12:0]        cur_pl;
  logic [22:0]        cur_base;
  logic               cur_vis;
  logic [3:0]         cur_held;
  logic               cur_hv;
  logic [23:0]        product;
  logic               new_vis;
  logic [3:0]         hi_nib, lo_nib;
  logic signed [14:0] col0, col1;
  logic               vis0, vis1, pl_ge2, pl_zero;
  logic [22:0]        addr0;
  logic               emit_a, emit_b;
  wr_t                wr_a, wr_b;

  function automatic logic col_in(input logic rv, input logic signed [14:0] c,
                                  input logic [12:0] left, input logic [12:0] right);
    col_in = rv && (c >= $signed({2'b00, left})) && (c < $signed({2'b00, right}));
  endfunction

  // Pick the span state seen by this transaction
  always_comb begin
    product = {12'd0, row_y[11:0]} * {12'd0, cfg.row_stride};
    new_vis = ($signed({row_y[12], row_y}) >= $signed({1'b0, cfg.clip_top})) &&
              ($signed({row_y[12], row_y}) <  $signed({1'b0, cfg.clip_bottom}));
    if (span_start) begin
      cur_col  = {start_x[12], start_x};
      cur_pl   = (span_width > MAX_WIDTH) ? MAX_WIDTH : span_width;
      cur_vis  = new_vis;
      cur_base = new_vis ? product[22:0] : '0;
      cur_held = '0;
      cur_hv   = 1'b0;
    end else begin
      cur_col  = next_col_r;
      cur_pl   = pix_left_r;
      cur_vis  = row_vis_r;
      cur_base = row_base_r;
      cur_held = held_r;
      cur_hv   = held_vld_r;
    end
  end

  // Build the writes and the next span state
  always_comb begin
    hi_nib  = pixel_pair[7:4];
    lo_nib  = pixel_pair[3:0];
    col0    = {cur_col[13], cur_col};
    col1    = col0 + 15'sd1;
    pl_zero = (cur_pl == '0);
    pl_ge2  = (cur_pl >= 13'd2);
    vis0    = col_in(cur_vis, col0, cfg.clip_left, cfg.clip_right);
    vis1    = col_in(cur_vis, col1, cfg.clip_left, cfg.clip_right);
    addr0   = cur_base + {11'd0, cur_col[12:1]};

    emit_a  = 1'b0;
    emit_b  = 1'b0;
    wr_a.addr = addr0;
    // The trailing pixel sits one column on; its column is never negative
    wr_b.addr = cur_base + {10'd0, col1[13:1]};
    wr_b.data = {lo_nib, 4'h0} & HI_MASK;
    wr_b.wr_hi = 1'b1;
    wr_b.wr_lo = 1'b0;
    wr_b.last  = 1'b1;

    next_col_nxt = cur_col;
    pix_left_nxt = cur_pl;
    row_base_nxt = cur_base;
    row_vis_nxt  = cur_vis;
    held_nxt     = cur_held;
    held_vld_nxt = cur_hv;

    if (!cur_col[0]) begin
      // Even column: both pixels land in one byte
      wr_a.data  = ({hi_nib, 4'h0} & {8{vis0}} & HI_MASK) |
                   ({4'h0, lo_nib} & {8{vis1 && pl_ge2}} & LO_MASK);
      wr_a.wr_hi = vis0;
      wr_a.wr_lo = vis1 && pl_ge2;
      emit_a     = !pl_zero && (vis0 || (vis1 && pl_ge2));
    end else begin
      // Odd column: merge the held pixel, hold the second one or write it at span end
      wr_a.data  = ({cur_held, 4'h0} & {8{cur_hv}} & HI_MASK) |
                   ({4'h0, hi_nib} & {8{vis0}} & LO_MASK);
      wr_a.wr_hi = cur_hv;
      wr_a.wr_lo = vis0;
      emit_a     = !pl_zero && (vis0 || cur_hv);
      emit_b     = (cur_pl == 13'd2) && vis1;
      if (!pl_zero) begin
        held_vld_nxt = 1'b0;
        if (pl_ge2 && (cur_pl != 13'd2)) begin
          held_nxt     = lo_nib;
          held_vld_nxt = vis1;
        end
      end
    end
    wr_a.last = !emit_b;

    // Advance the span
    if (!pl_zero) begin
      pix_left_nxt = pl_ge2 ? cur_pl - 13'd2 : '0;
      next_col_nxt = cur_col + (pl_ge2 ? 14'sd2 : 14'sd1);
    end

    push.n      = {1'b0, emit_a} + {1'b0, emit_b};
    push.first  = emit_a ? wr_a : wr_b;
    push.second = wr_b;
  end

  // Hold span state, update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_col_r <= '0;
      pix_left_r <= '0;
      row_base_r <= '0;
      row_vis_r  <= 1'b0;
      held_r     <= '0;
      held_vld_r <= 1'b0;
    end else if (acc) begin
      next_col_r <= next_col_nxt;
      pix_left_r <= pix_left_nxt;
      row_base_r <= row_base_nxt;
      row_vis_r  <= row_vis_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

  // No active span means no writes
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (!span_start && pix_left_r == '0) |-> (push.n == 2'd0))
    else $error("write produced without an active span");

  // Two writes only come from an odd-aligned final pair
  a_two_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (cur_col[0] && cur_pl == 13'd2))
    else $error("two writes outside odd-aligned span end");

  // A held pixel is always consumed or dropped before an even column
  a_held_odd: assert property (@(posedge clk) disable iff (!rst_n)
    held_vld_r |-> next_col_r[0])
    else $error("held pixel pending at even column");

endmodule

/* src/p4sw_outq.sv */
// Three-entry output queue that takes up to two writes per cycle.
module p4sw_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_en,
  input  p4sw_pkg::push_t  push,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output p4sw_pkg::wr_t    out_wr
);
  import p4sw_pkg::*;

  localparam int Depth = 3;

  wr_t        q_r   [Depth];
  wr_t        q_nxt [Depth];
  logic [1:0] count_r, count_nxt;
  logic [1:0] base;
  logic [1:0] npush;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign out_wr    = q_r[0];
  assign pop       = out_valid && !out_stall;
  // Room for two writes is needed before a transaction is taken
  assign full      = (count_r > 2'd1);

  // Shift out on pop, append the new writes behind the rest
  always_comb begin
    npush = push_en ? push.n : 2'd0;
    base  = count_r - {1'b0, pop};
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (npush != 2'd0 && base == 2'(i)) begin
        q_nxt[i] = push.first;
      end
      if (npush == 2'd2 && base + 2'd1 == 2'(i)) begin
        q_nxt[i] = push.second;
      end
    end
    count_nxt = base + npush;
  end

  // Hold the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd3)
    else $error("output queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (npush != 2'd0) |-> (count_r <= 2'd1))
    else $error("push without room for two writes");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (count_r >= $past(count_r)))
    else $error("write lost while output stalled");

endmodule

/* src/packed_4bpp_span_write.sv */
// Top level of the packed 4bpp span writer: configuration, span logic, output queue.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   span_start start_x row_y span_width pixel_pair
//  out_     output     out_valid / out_stall byte_address byte_data write_high write_low last
//  cfg_     input      cfg_we                cfg_index cfg_data
//
// One source byte is taken per cycle while in_stall is low; it yields zero,
// one or two byte writes. A byte that yields two writes is drained from the
// three-entry output queue by the one-write-per-cycle output port.
// The writes of an accepted transaction are registered in the output queue.
// in_stall rises while more than one write waits, whatever out_stall does.
// Synchronous active-low reset clears span state and the queue, clip registers
// return to the full 4096 x 4096 area with a 2048-byte stride.
module packed_4bpp_span_write (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_span_start,
  input  logic signed [12:0] in_start_x,
  input  logic signed [12:0] in_row_y,
  input  logic [12:0]        in_span_width,
  input  logic [7:0]         in_pixel_pair,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [22:0]        out_byte_address,
  output logic [7:0]         out_byte_data,
  output logic               out_write_high,
  output logic               out_write_low,
  output logic               out_last
);
  import p4sw_pkg::*;

  cfg_t  cfg_r;
  push_t push;
  wr_t   out_wr;
  logic  q_full;
  logic  acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left   <= 13'd0;
      cfg_r.clip_right  <= 13'd4096;
      cfg_r.clip_top    <= 13'd0;
      cfg_r.clip_bottom <= 13'd4096;
      cfg_r.row_stride  <= 12'd2048;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LEFT:   cfg_r.clip_left   <= cfg_data;
        CFG_CLIP_RIGHT:  cfg_r.clip_right  <= cfg_data;
        CFG_CLIP_TOP:    cfg_r.clip_top    <= cfg_data;
        CFG_CLIP_BOTTOM: cfg_r.clip_bottom <= cfg_data;
        CFG_ROW_STRIDE:  cfg_r.row_stride  <= cfg_data[StrideW-1:0];
        default: ;
      endcase
    end
  end

  p4sw_span u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .acc        (acc),
    .span_start (in_span_start),
    .start_x    (in_start_x),
    .row_y      (in_row_y),
    .span_width (in_span_width),
    .pixel_pair (in_pixel_pair),
    .push       (push)
  );

  p4sw_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (acc),
    .push      (push),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_wr    (out_wr)
  );

  assign out_byte_address = out_wr.addr;
  assign out_byte_data    = out_wr.data;
  assign out_write_high   = out_wr.wr_hi;
  assign out_write_low    = out_wr.wr_lo;
  assign out_last         = out_wr.last;

endmodule
